[rtl/dpss_pkg.sv]
// ----------------------------------------------------------------------------
// dpss_pkg
// Types and constants of the dual pressure sensor sequencer.
// ----------------------------------------------------------------------------
package dpss_pkg;

	// Sensor register map and command values
	localparam logic [7:0]  REG_CTRL     = 8'hA5;
	localparam logic [10:0] CTRL_MASK    = 11'h7FD;
	localparam logic [7:0]  REG_CMD      = 8'h30;
	localparam logic [10:0] CMD_START    = 11'h00A;
	localparam int unsigned CMD_BUSY_BIT = 3;
	localparam logic [7:0]  REG_DATA     = 8'h06;

	// Range scaling: shift of the 24-bit reading saturates at eight
	localparam logic [3:0]  MAX_SHIFT    = 4'd8;

	// Transfer width codes
	localparam logic [1:0]  WC_8  = 2'd0;
	localparam logic [1:0]  WC_16 = 2'd1;
	localparam logic [1:0]  WC_24 = 2'd2;

	// Configuration register indexes
	localparam logic REG_IDX_RANGE_A = 1'b0;
	localparam logic REG_IDX_RANGE_B = 1'b1;

	// Reset values of the range registers
	localparam logic [3:0] RANGE_A_RST = 4'd2;
	localparam logic [3:0] RANGE_B_RST = 4'd8;

	localparam int unsigned IN_W  = 88;
	localparam int unsigned OUT_W = 200;

	// Measurement sequence steps
	typedef enum logic [2:0] {
		ST_START    = 3'd0,
		ST_CTRL_WB  = 3'd1,
		ST_CMD_WR   = 3'd2,
		ST_POLL_RD  = 3'd3,
		ST_POLL_CHK = 3'd4,
		ST_RESULT   = 3'd5
	} step_t;

	// One loop tick, last field in the lowest bits
	typedef struct packed {
		logic [3:0]  pad;
		logic [31:0] now_us;
		logic [23:0] read_data_b;
		logic [23:0] read_data_a;
		logic        fault_b;
		logic        fault_a;
		logic        busy_b;
		logic        busy_a;
	} tick_t;

	// One result, last field in the lowest bits
	typedef struct packed {
		logic [4:0]  pad;
		logic [31:0] worst_duration_us;
		logic [31:0] failed_count;
		logic [31:0] total_count;
		logic        error_flag;
		logic [31:0] pressure_b;
		logic [31:0] pressure_a;
		logic [10:0] write_data_b;
		logic [10:0] write_data_a;
		logic [1:0]  width_code;
		logic [7:0]  reg_addr;
		logic        issue_write;
		logic        issue;
	} result_t;

	// Sign-extend a 24-bit reading and scale it into Pa in Q11
	function automatic logic [31:0] scale_raw(input logic [23:0] raw, input logic [3:0] code);
		logic [3:0]  sh;
		logic [31:0] ext;
		sh  = (code > MAX_SHIFT) ? MAX_SHIFT : code;
		ext = {{8{raw[23]}}, raw};
		return ext << sh;
	endfunction

endpackage

[rtl/dual_pressure_sensor_sequencer_top.sv]
// ----------------------------------------------------------------------------
// dual_pressure_sensor_sequencer_top
// Paces two pressure sensors in lockstep, one loop tick per request.
// ----------------------------------------------------------------------------
// One result request leaves for every tick request taken. The block takes a
// tick in every clock cycle unless result backpressure holds it. The tick is
// taken into the input register, and the result register loads from it when
// the result side is free. All sequence and status logic sits between those two
// registers and updates the state as the result is loaded. Backpressure on the
// result side stalls the input side only when both registers are full. Range
// registers sit at byte addresses 0 and 4.
module dual_pressure_sensor_sequencer_top
	import dpss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// tick: busy_a, busy_b, fault_a, fault_b, read_data_a, read_data_b, now_us
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_W-1:0]     s_tdata,
	// result: issue, issue_write, reg_addr, width_code, write_data_a,
	// write_data_b, pressure_a, pressure_b, error_flag, total_count,
	// failed_count, worst_duration_us
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [3:0] range_a_q, range_b_q;

	logic        valid_s1;
	tick_t       tick_s1;
	logic        out_free, adv;

	step_t       step_q, step_d;
	logic        err_q, err_d;
	logic [31:0] started_q, started_d;
	logic [31:0] completed_q, completed_d;
	logic [31:0] stamp_q, stamp_d;
	logic [31:0] worst_q, worst_d;
	logic [31:0] press_a_q, press_a_d;
	logic [31:0] press_b_q, press_b_d;
	logic [31:0] dur;
	logic        busy, fault, poll_busy;

	logic        iss, wr;
	logic [7:0]  addr;
	logic [1:0]  wc;
	logic [10:0] wda, wdb;

	result_t     res_d, res_q;
	logic        out_valid_q;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_a_q <= RANGE_A_RST;
			range_b_q <= RANGE_B_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_IDX_RANGE_A: range_a_q <= pwdata[3:0];
				REG_IDX_RANGE_B: range_b_q <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IDX_RANGE_A: prdata = {28'd0, range_a_q};
			REG_IDX_RANGE_B: prdata = {28'd0, range_b_q};
		endcase
	end

	// Handshake: advance the input register into the result register
	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1 <= tick_t'(s_tdata);
		end
	end

	// Decode the tick
	assign busy      = tick_s1.busy_a | tick_s1.busy_b;
	assign fault     = tick_s1.fault_a | tick_s1.fault_b;
	assign poll_busy = tick_s1.read_data_a[CMD_BUSY_BIT] | tick_s1.read_data_b[CMD_BUSY_BIT];
	assign dur       = tick_s1.now_us - stamp_q;

	// Next state and status
	always_comb begin
		step_d      = step_q;
		err_d       = err_q;
		started_d   = started_q;
		completed_d = completed_q;
		stamp_d     = stamp_q;
		worst_d     = worst_q;
		press_a_d   = press_a_q;
		press_b_d   = press_b_q;
		unique case (step_q)
			ST_START: begin
				if (started_q != '1) begin
					started_d = started_q + 32'd1;
				end
				stamp_d = tick_s1.now_us;
				step_d  = ST_CTRL_WB;
			end
			ST_CTRL_WB, ST_CMD_WR, ST_POLL_RD, ST_POLL_CHK, ST_RESULT: begin
				if (!busy) begin
					priority if (fault) begin
						err_d  = 1'b1;
						step_d = ST_START;
					end else if (step_q == ST_CTRL_WB) begin
						step_d = ST_CMD_WR;
					end else if (step_q == ST_CMD_WR) begin
						step_d = ST_POLL_RD;
					end else if (step_q == ST_POLL_RD) begin
						step_d = ST_POLL_CHK;
					end else if (step_q == ST_POLL_CHK) begin
						step_d = poll_busy ? ST_POLL_RD : ST_RESULT;
					end else begin
						press_a_d = scale_raw(tick_s1.read_data_a, range_a_q);
						press_b_d = scale_raw(tick_s1.read_data_b, range_b_q);
						err_d     = 1'b0;
						if (completed_q != '1) begin
							completed_d = completed_q + 32'd1;
						end
						if (dur > worst_q) begin
							worst_d = dur;
						end
						step_d = ST_START;
					end
				end
			end
			default: step_d = ST_START;
		endcase
	end

	// Bus transaction outputs
	always_comb begin
		iss  = 1'b0;
		wr   = 1'b0;
		addr = '0;
		wc   = WC_8;
		wda  = '0;
		wdb  = '0;
		unique case (step_q)
			ST_START: begin
				iss  = 1'b1;
				addr = REG_CTRL;
				wc   = WC_16;
			end
			ST_CTRL_WB: begin
				if (!busy && !fault) begin
					iss  = 1'b1;
					wr   = 1'b1;
					addr = REG_CTRL;
					wc   = WC_16;
					wda  = tick_s1.read_data_a[10:0] & CTRL_MASK;
					wdb  = tick_s1.read_data_b[10:0] & CTRL_MASK;
				end
			end
			ST_CMD_WR: begin
				if (!busy && !fault) begin
					iss  = 1'b1;
					wr   = 1'b1;
					addr = REG_CMD;
					wc   = WC_8;
					wda  = CMD_START;
					wdb  = CMD_START;
				end
			end
			ST_POLL_RD: begin
				if (!busy && !fault) begin
					iss  = 1'b1;
					addr = REG_CMD;
					wc   = WC_8;
				end
			end
			ST_POLL_CHK: begin
				if (!busy && !fault && !poll_busy) begin
					iss  = 1'b1;
					addr = REG_DATA;
					wc   = WC_24;
				end
			end
			default: begin
				iss = 1'b0;
			end
		endcase
	end

	// Assemble the result from the updated state
	always_comb begin
		res_d                   = '0;
		res_d.issue             = iss;
		res_d.issue_write       = wr;
		res_d.reg_addr          = addr;
		res_d.width_code        = wc;
		res_d.write_data_a      = wda;
		res_d.write_data_b      = wdb;
		res_d.pressure_a        = press_a_d;
		res_d.pressure_b        = press_b_d;
		res_d.error_flag        = err_d;
		res_d.total_count       = started_d;
		res_d.failed_count      = started_d - completed_d;
		res_d.worst_duration_us = worst_d;
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_START;
			err_q       <= 1'b0;
			started_q   <= '0;
			completed_q <= '0;
			stamp_q     <= '0;
			worst_q     <= '0;
			press_a_q   <= '0;
			press_b_q   <= '0;
		end else if (adv) begin
			step_q      <= step_d;
			err_q       <= err_d;
			started_q   <= started_d;
			completed_q <= completed_d;
			stamp_q     <= stamp_d;
			worst_q     <= worst_d;
			press_a_q   <= press_a_d;
			press_b_q   <= press_b_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(res_q);

endmodule

[rtl/dpss_checker.sv]
// ----------------------------------------------------------------------------
// dpss_checker
// Port-level checks of the sequencer's result stream.
// ----------------------------------------------------------------------------
module dpss_checker
	import dpss_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// A stalled result request holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// No transaction: address, width, direction and write data are all zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[33:1] == 33'd0)
		else $error("transaction fields set without issue");

	// Write data only goes out with a write
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[33:12] == 22'd0)
		else $error("write data set on a read");

	// Width code three is never used
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[11:10] != 2'd3)
		else $error("invalid width code");

	// Failed count never exceeds the started count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[162:131] <= m_tdata[130:99])
		else $error("failed count above total count");

endmodule

bind dual_pressure_sensor_sequencer_top dpss_checker u_dpss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual pressure sensor sequencer.
// A short scripted run walks the measurement sequence through waits, bus
// faults, poll retries, timestamp wrap and reading extremes. Random phases
// follow, each under its own pair of range codes. Every result request is
// compared field by field with an in-bench model of the sequencer.
// ----------------------------------------------------------------------------
module tb;
	import dpss_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int N_ROWS       = 25;
	localparam int N_PHASES     = 6;
	localparam int PHASE_TICKS  = 240;
	localparam int DRAIN_CYCLES = 8;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// tick: busy_a, busy_b, fault_a, fault_b, read_data_a, read_data_b, now_us
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// result: issue, issue_write, reg_addr, width_code, write_data_a,
	// write_data_b, pressure_a, pressure_b, error_flag, total_count,
	// failed_count, worst_duration_us
	logic [OUT_W-1:0]    m_tdata;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [2:0]          paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	dual_pressure_sensor_sequencer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Sequencer model state
	step_t       seq_step       = ST_START;
	logic        bus_error      = 1'b0;
	logic [31:0] n_started      = '0;
	logic [31:0] n_completed    = '0;
	logic [31:0] stamp_at_start = '0;
	logic [31:0] worst_us       = '0;
	logic [31:0] held_pa        = '0;
	logic [31:0] held_pb        = '0;
	logic [3:0]  range_a        = RANGE_A_RST;
	logic [3:0]  range_b        = RANGE_B_RST;

	result_t     pending_results [$];
	int          error_count    = 0;
	int          cycle_count    = 0;
	logic [31:0] clock_us       = '0;
	int          burst_left     = 0;

	// Scripted row: tick fields, then the control fields typed in by hand
	typedef struct packed {
		logic        busy_a;
		logic        busy_b;
		logic        fault_a;
		logic        fault_b;
		logic [23:0] rd_a;
		logic [23:0] rd_b;
		logic [31:0] now;
		logic        typed;
		logic        issue;
		logic        wr;
		logic [7:0]  addr;
		logic [1:0]  wc;
		logic        err;
	} script_row_t;

	script_row_t script [N_ROWS] = '{
		// start after reset: read control register
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0000,
			1'b1, 1'b1, 1'b0, REG_CTRL, WC_16, 1'b0},
		// either master busy: wait
		'{1'b1, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0001,
			1'b1, 1'b0, 1'b0, 8'h00, WC_8, 1'b0},
		'{1'b0, 1'b1, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0002,
			1'b1, 1'b0, 1'b0, 8'h00, WC_8, 1'b0},
		// write back masked control, all ones on A and zero on B
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'hFFFFFF, 24'h000000, 32'h0000_0003,
			1'b1, 1'b1, 1'b1, REG_CTRL, WC_16, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'hFFFFFF, 32'h0000_0004,
			1'b1, 1'b1, 1'b1, REG_CMD, WC_8, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0005,
			1'b1, 1'b1, 1'b0, REG_CMD, WC_8, 1'b0},
		// poll bit set on A, then on B: go back and poll again
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000008, 24'h000000, 32'h0000_0006,
			1'b1, 1'b0, 1'b0, 8'h00, WC_8, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0007,
			1'b1, 1'b1, 1'b0, REG_CMD, WC_8, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000008, 32'h0000_0008,
			1'b1, 1'b0, 1'b0, 8'h00, WC_8, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0009,
			1'b1, 1'b1, 1'b0, REG_CMD, WC_8, 1'b0},
		// poll bit clear, every other bit set: read the result
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'hFFFFF7, 24'hFFFFF7, 32'h0000_000A,
			1'b1, 1'b1, 1'b0, REG_DATA, WC_24, 1'b0},
		'{1'b1, 1'b1, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_000B,
			1'b1, 1'b0, 1'b0, 8'h00, WC_8, 1'b0},
		// most negative and most positive readings
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h800000, 24'h7FFFFF, 32'h0000_0064,
			1'b0, 1'b0, 1'b0, 8'h00, WC_8, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'hFFFF_FFF0,
			1'b1, 1'b1, 1'b0, REG_CTRL, WC_16, 1'b0},
		// bus fault on A aborts the cycle
		'{1'b0, 1'b0, 1'b1, 1'b0, 24'h000000, 24'h000000, 32'hFFFF_FFF4,
			1'b1, 1'b0, 1'b0, 8'h00, WC_8, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'hFFFF_FFF8,
			1'b1, 1'b1, 1'b0, REG_CTRL, WC_16, 1'b1},
		// busy wins over a fault
		'{1'b1, 1'b0, 1'b0, 1'b1, 24'h000000, 24'h000000, 32'hFFFF_FFF9,
			1'b1, 1'b0, 1'b0, 8'h00, WC_8, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1, 24'h000000, 24'h000000, 32'hFFFF_FFFA,
			1'b1, 1'b0, 1'b0, 8'h00, WC_8, 1'b1},
		// full cycle across the timestamp wrap
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'hFFFF_FFFF,
			1'b1, 1'b1, 1'b0, REG_CTRL, WC_16, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h0007FF, 24'hFFF802, 32'h0000_0010,
			1'b0, 1'b0, 1'b0, 8'h00, WC_8, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0020,
			1'b1, 1'b1, 1'b1, REG_CMD, WC_8, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0030,
			1'b1, 1'b1, 1'b0, REG_CMD, WC_8, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h000000, 24'h000000, 32'h0000_0040,
			1'b1, 1'b1, 1'b0, REG_DATA, WC_24, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b0, 24'h7FFFFF, 24'h800000, 32'h0000_0200,
			1'b0, 1'b0, 1'b0, 8'h00, WC_8, 1'b0},
		// start ignores busy and fault
		'{1'b1, 1'b0, 1'b1, 1'b0, 24'h000000, 24'h000000, 32'h0000_0300,
			1'b1, 1'b1, 1'b0, REG_CTRL, WC_16, 1'b0}
	};

	// Sign-extend a 24-bit reading and apply the range shift
	function automatic logic [31:0] to_pa_q11(input logic [23:0] raw, input logic [3:0] code);
		logic signed [31:0] wide;
		int                 shamt;
		wide  = 32'(signed'(raw));
		shamt = (code > MAX_SHIFT) ? int'(MAX_SHIFT) : int'(code);
		return 32'(wide <<< shamt);
	endfunction

	// Advance the sequence by one tick and build the result it produces
	task automatic advance_sequence(input tick_t t, output result_t r);
		logic        busy;
		logic        fault;
		logic [31:0] dur;
		busy = t.busy_a | t.busy_b;
		fault = t.fault_a | t.fault_b;
		r = '0;
		if (seq_step == ST_START) begin
			if (n_started != 32'hFFFF_FFFF)
				n_started = n_started + 32'd1;
			stamp_at_start = t.now_us;
			r.issue = 1'b1;
			r.reg_addr = REG_CTRL;
			r.width_code = WC_16;
			seq_step = ST_CTRL_WB;
		end else if (!busy) begin
			if (fault) begin
				bus_error = 1'b1;
				seq_step = ST_START;
			end else begin
				case (seq_step)
					ST_CTRL_WB: begin
						r.issue = 1'b1;
						r.issue_write = 1'b1;
						r.reg_addr = REG_CTRL;
						r.width_code = WC_16;
						r.write_data_a = t.read_data_a[10:0] & CTRL_MASK;
						r.write_data_b = t.read_data_b[10:0] & CTRL_MASK;
						seq_step = ST_CMD_WR;
					end
					ST_CMD_WR: begin
						r.issue = 1'b1;
						r.issue_write = 1'b1;
						r.reg_addr = REG_CMD;
						r.width_code = WC_8;
						r.write_data_a = CMD_START;
						r.write_data_b = CMD_START;
						seq_step = ST_POLL_RD;
					end
					ST_POLL_RD: begin
						r.issue = 1'b1;
						r.reg_addr = REG_CMD;
						r.width_code = WC_8;
						seq_step = ST_POLL_CHK;
					end
					ST_POLL_CHK: begin
						if (t.read_data_a[CMD_BUSY_BIT] | t.read_data_b[CMD_BUSY_BIT]) begin
							seq_step = ST_POLL_RD;
						end else begin
							r.issue = 1'b1;
							r.reg_addr = REG_DATA;
							r.width_code = WC_24;
							seq_step = ST_RESULT;
						end
					end
					ST_RESULT: begin
						dur = t.now_us - stamp_at_start;
						held_pa = to_pa_q11(t.read_data_a, range_a);
						held_pb = to_pa_q11(t.read_data_b, range_b);
						bus_error = 1'b0;
						if (n_completed != 32'hFFFF_FFFF)
							n_completed = n_completed + 32'd1;
						if (dur > worst_us)
							worst_us = dur;
						seq_step = ST_START;
					end
					default: begin
						seq_step = ST_START;
					end
				endcase
			end
		end
		r.pressure_a = held_pa;
		r.pressure_b = held_pb;
		r.error_flag = bus_error;
		r.total_count = n_started;
		r.failed_count = n_started - n_completed;
		r.worst_duration_us = worst_us;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Compare one result request with the oldest expectation
	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected result", got.total_count, 32'h0);
		end else begin
			want = pending_results.pop_front();
			check_field("issue", 32'(got.issue), 32'(want.issue));
			check_field("issue_write", 32'(got.issue_write), 32'(want.issue_write));
			check_field("reg_addr", 32'(got.reg_addr), 32'(want.reg_addr));
			check_field("width_code", 32'(got.width_code), 32'(want.width_code));
			check_field("write_data_a", 32'(got.write_data_a), 32'(want.write_data_a));
			check_field("write_data_b", 32'(got.write_data_b), 32'(want.write_data_b));
			check_field("pressure_a", got.pressure_a, want.pressure_a);
			check_field("pressure_b", got.pressure_b, want.pressure_b);
			check_field("error_flag", 32'(got.error_flag), 32'(want.error_flag));
			check_field("total_count", got.total_count, want.total_count);
			check_field("failed_count", got.failed_count, want.failed_count);
			check_field("worst_duration_us", got.worst_duration_us, want.worst_duration_us);
		end
	endtask

	// Offer one tick, sometimes idling first when a burst has run out
	task automatic send_tick(input tick_t t);
		int   gap;
		logic took;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
	endtask

	// Write a range register over APB, then read it back
	task automatic write_range(input logic idx, input logic [3:0] code);
		logic [31:0] back;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {28'($urandom), code};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		back = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field(idx == REG_IDX_RANGE_A ? "range_code_a readback" : "range_code_b readback",
			32'(back[3:0]), 32'(code));
		if (idx == REG_IDX_RANGE_A)
			range_a = code;
		else
			range_b = code;
	endtask

	// Random tick: mostly clean bus traffic, some noise
	task automatic next_tick(output tick_t t);
		t = '0;
		if ($urandom_range(0, 9) == 0) begin
			t.busy_a = ($urandom_range(0, 1) == 1);
			t.busy_b = ($urandom_range(0, 1) == 1);
			t.fault_a = ($urandom_range(0, 1) == 1);
			t.fault_b = ($urandom_range(0, 1) == 1);
			t.now_us = $urandom;
		end else begin
			t.busy_a = ($urandom_range(0, 5) == 0);
			t.busy_b = ($urandom_range(0, 5) == 0);
			t.fault_a = ($urandom_range(0, 40) == 0);
			t.fault_b = ($urandom_range(0, 40) == 0);
			if ($urandom_range(0, 49) == 0)
				clock_us = $urandom;
			else
				clock_us = clock_us + 32'($urandom_range(0, 40));
			t.now_us = clock_us;
		end
		t.read_data_a = 24'($urandom);
		t.read_data_b = 24'($urandom);
		// clear the poll bit on both half the time so results get through
		if ($urandom_range(0, 1) == 1) begin
			t.read_data_a[CMD_BUSY_BIT] = 1'b0;
			t.read_data_b[CMD_BUSY_BIT] = 1'b0;
		end
	endtask

	task automatic wait_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: always ready or stalling in one of three modes, picking a new random mode when one runs out
	int rx_mode = 0;
	int rx_left = 0;
	int rx_count = 0;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(50, 300);
		end
		rx_left--;
		rx_count++;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (rx_count % 3 == 0);
			default: m_tready <= (rx_count % 16 > 11);
		endcase
	end

	// Sample result requests mid-cycle, check at the next edge
	logic    rx_fire = 1'b0;
	result_t rx_data;
	always @(negedge clk) begin
		rx_fire = m_tvalid && m_tready;
		rx_data = m_tdata;
	end

	always @(posedge clk) begin
		if (rx_fire)
			check_result(rx_data);
	end

	// Drop the run when it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		tick_t       t;
		result_t     want;
		int          done;
		logic [3:0]  plan_a [4];
		logic [3:0]  plan_b [4];
		logic [3:0]  code_a;
		logic [3:0]  code_b;
		plan_a = '{4'd0, 4'd9, 4'd15, 4'd12};
		plan_b = '{4'd9, 4'd0, 4'd10, 4'd3};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted part under the reset ranges
		for (int i = 0; i < N_ROWS; i++) begin
			t = '0;
			t.busy_a = script[i].busy_a;
			t.busy_b = script[i].busy_b;
			t.fault_a = script[i].fault_a;
			t.fault_b = script[i].fault_b;
			t.read_data_a = script[i].rd_a;
			t.read_data_b = script[i].rd_b;
			t.now_us = script[i].now;
			send_tick(t);
			advance_sequence(t, want);
			if (script[i].typed) begin
				want.issue = script[i].issue;
				want.issue_write = script[i].wr;
				want.reg_addr = script[i].addr;
				want.width_code = script[i].wc;
				want.error_flag = script[i].err;
			end
			pending_results.push_back(want);
		end
		s_tvalid <= 1'b0;
		clock_us = 32'h0000_0400;

		// Random phases, each under new range codes
		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			if (p < 4) begin
				code_a = plan_a[p];
				code_b = plan_b[p];
			end else begin
				code_a = 4'($urandom_range(0, 15));
				code_b = 4'($urandom_range(0, 15));
			end
			write_range(REG_IDX_RANGE_A, code_a);
			write_range(REG_IDX_RANGE_B, code_b);
			done = 0;
			while (done < PHASE_TICKS) begin
				next_tick(t);
				done++;
				send_tick(t);
				advance_sequence(t, want);
				pending_results.push_back(want);
			end
			s_tvalid <= 1'b0;
		end

		wait_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
